// ===== src/mrgd_pkg.sv =====
// Shared types, constants and helpers for the multicode regular graph decoder.
// No dependencies; used by every module of the block.
package mrgd_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned DEGREE       = 3;
  localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_PW       = $clog2(OUT_DEPTH);

  localparam logic [7:0] MAX_V8 = 8'(MAX_VERTICES);
  localparam logic [2:0] DEG3   = 3'(DEGREE);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VERTS = 2'd1,
    ST_RANGE = 2'd2,
    ST_IRREG = 2'd3
  } status_e;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_SUM  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  from_vertex;
    logic [7:0]  to_vertex;
    logic [2:0]  from_slot;
    logic [2:0]  to_slot;
    logic [7:0]  vertex_count;
    logic [8:0]  edge_count;
    status_e     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [2:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_w_addr;
    logic [ADDR_W-1:0] rd_nx_addr;
  } mem_req_t;

  // code bytes that follow a header of n vertices
  function automatic logic [9:0] hdr_len(input logic [7:0] n);
    logic [10:0] prod;
    logic [10:0] len;
    prod = 11'(n) * 11'(DEGREE);
    len  = (prod >> 1) + 11'(n) - 11'd1;
    return (n == 8'd0) ? 10'd0 : len[9:0];
  endfunction

  function automatic logic [8:0] edge_cnt(input logic [7:0] n);
    logic [10:0] prod;
    prod = 11'(n) * 11'(DEGREE);
    return prod[9:1];
  endfunction

  function automatic logic [2:0] sat_add(input logic [2:0] old, input logic [1:0] amt);
    logic [3:0] sum;
    sum = 4'(old) + 4'(amt);
    return (sum > 4'd7) ? 3'd7 : sum[2:0];
  endfunction

  function automatic logic [7:0] full_step(input logic [7:0] full, input logic [2:0] old,
                                           input logic [2:0] now);
    logic [7:0] f;
    f = full;
    if (old == DEG3 && f != 8'd0) f = f - 8'd1;
    if (now == DEG3) f = f + 8'd1;
    return f;
  endfunction

endpackage

// ===== src/mrgd_deg_mem.sv =====
// Degree memory: one write port, two registered read ports.
// Depends on mrgd_pkg for the depth and the request struct.
module mrgd_deg_mem (
  input  logic                clk_i,
  input  mrgd_pkg::mem_req_t  req_i,
  output logic [2:0]          rd_w_o,
  output logic [2:0]          rd_nx_o
);

  logic [2:0] mem_q [mrgd_pkg::MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_w_o  <= mem_q[req_i.rd_w_addr];
      rd_nx_o <= mem_q[req_i.rd_nx_addr];
    end
  end

endmodule

// ===== src/mrgd_core.sv =====
// Input stage, decoder state and per-byte update logic.
// Depends on mrgd_pkg; drives mrgd_deg_mem and pushes into mrgd_out_fifo.
module mrgd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          code_byte_i,
  output logic                stall_o,
  output mrgd_pkg::mem_req_t  mem_req_o,
  input  logic [2:0]          rd_w_i,
  input  logic [2:0]          rd_nx_i,
  input  logic                space_ok_i,
  output mrgd_pkg::push_t     push_o
);

  localparam int unsigned AW = mrgd_pkg::ADDR_W;

  logic                          stg_vld_q, stg_vld_d;
  logic [7:0]                    stg_byte_q;
  logic                          fwd_en_q;
  logic [AW-1:0]                 fwd_addr_q;
  logic [2:0]                    fwd_data_q;
  logic                          await_q, await_d;
  logic [9:0]                    bl_q, bl_d;
  logic [7:0]                    cur_v_q, cur_v_d;
  logic [7:0]                    n_q, n_d;
  logic [7:0]                    full_q, full_d;
  mrgd_pkg::status_e             err_q, err_d;
  logic [2:0]                    cur_deg_q, cur_deg_d;
  logic [mrgd_pkg::MAX_VERTICES-1:0] vld_q;

  logic          adv, acc, clr_vld;
  logic [7:0]    w8, in_w8, nx8, nx_cur8;
  logic [AW-1:0] w_addr, nx_addr;
  logic [9:0]    bl_dec;
  logic [2:0]    eff_w, eff_nx, ts, now_v, now_w, now_loop;
  logic [7:0]    f1, f2, f_loop;
  logic          is_zero, is_loop, v_in, v_ok, w_ok;
  logic          edge_emit, sum_emit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_data;
  mrgd_pkg::res_t    edge_res, sum_res;
  mrgd_pkg::status_e sum_st;

  assign adv     = stg_vld_q & space_ok_i;
  assign stall_o = stg_vld_q & ~space_ok_i;
  assign acc     = valid_i & ~stall_o;
  assign stg_vld_d = acc | (stg_vld_q & ~adv);

  assign w8      = stg_byte_q - 8'd1;
  assign w_addr  = w8[AW-1:0];
  assign nx_cur8 = cur_v_q + 8'd1;
  assign nx_addr = nx_cur8[AW-1:0];
  assign bl_dec  = bl_q - 10'd1;
  assign is_zero = (stg_byte_q == 8'd0);
  assign is_loop = (w8 == cur_v_q);
  assign v_in    = (cur_v_q < mrgd_pkg::MAX_V8);
  assign v_ok    = v_in && (cur_v_q < n_q);
  assign w_ok    = (w8 < mrgd_pkg::MAX_V8) && (w8 < n_q);

  // reads were issued at accept; patch in the write from that same edge
  assign eff_w  = !vld_q[w_addr] ? 3'd0 :
                  (fwd_en_q && fwd_addr_q == w_addr) ? fwd_data_q : rd_w_i;
  assign eff_nx = !vld_q[nx_addr] ? 3'd0 :
                  (fwd_en_q && fwd_addr_q == nx_addr) ? fwd_data_q : rd_nx_i;

  assign ts       = is_loop ? cur_deg_q : eff_w;
  assign now_v    = mrgd_pkg::sat_add(cur_deg_q, 2'd1);
  assign now_w    = mrgd_pkg::sat_add(eff_w, 2'd1);
  assign now_loop = mrgd_pkg::sat_add(cur_deg_q, 2'd2);
  assign f1       = mrgd_pkg::full_step(full_q, cur_deg_q, now_v);
  assign f2       = mrgd_pkg::full_step(f1, eff_w, now_w);
  assign f_loop   = mrgd_pkg::full_step(full_q, cur_deg_q, now_loop);

  always_comb begin
    await_d   = await_q;
    bl_d      = bl_q;
    cur_v_d   = cur_v_q;
    n_d       = n_q;
    full_d    = full_q;
    err_d     = err_q;
    cur_deg_d = cur_deg_q;
    clr_vld   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_v_q[AW-1:0];
    wr_data   = cur_deg_q;
    edge_emit = 1'b0;
    sum_emit  = 1'b0;
    if (adv) begin
      if (await_q) begin
        await_d   = 1'b0;
        n_d       = stg_byte_q;
        cur_v_d   = 8'd0;
        full_d    = 8'd0;
        cur_deg_d = 3'd0;
        clr_vld   = 1'b1;
        err_d     = (stg_byte_q > mrgd_pkg::MAX_V8) ? mrgd_pkg::ST_VERTS : mrgd_pkg::ST_OK;
        bl_d      = mrgd_pkg::hdr_len(stg_byte_q);
        sum_emit  = (bl_d == 10'd0);
      end else begin
        bl_d = bl_dec;
        if (err_q != mrgd_pkg::ST_VERTS) begin
          if (is_zero) begin
            if (cur_v_q != 8'hFF) cur_v_d = nx_cur8;
            wr_en     = v_in;
            cur_deg_d = eff_nx;
          end else if (!v_ok || !w_ok) begin
            if (err_q == mrgd_pkg::ST_OK) err_d = mrgd_pkg::ST_RANGE;
          end else begin
            edge_emit = 1'b1;
            if (is_loop) begin
              cur_deg_d = now_loop;
              full_d    = f_loop;
            end else begin
              cur_deg_d = now_v;
              full_d    = f2;
              wr_en     = 1'b1;
              wr_addr   = w_addr;
              wr_data   = now_w;
            end
          end
        end
        sum_emit = (bl_dec == 10'd0);
      end
      if (sum_emit) await_d = 1'b1;
    end
  end

  assign sum_st = (err_d != mrgd_pkg::ST_OK) ? err_d :
                  (full_d != n_d) ? mrgd_pkg::ST_IRREG : mrgd_pkg::ST_OK;

  always_comb begin
    edge_res.kind         = mrgd_pkg::KIND_EDGE;
    edge_res.from_vertex  = cur_v_q;
    edge_res.to_vertex    = w8;
    edge_res.from_slot    = cur_deg_q;
    edge_res.to_slot      = ts;
    edge_res.vertex_count = n_q;
    edge_res.edge_count   = mrgd_pkg::edge_cnt(n_q);
    edge_res.status       = mrgd_pkg::ST_OK;
    edge_res.last         = 1'b0;
    sum_res.kind          = mrgd_pkg::KIND_SUM;
    sum_res.from_vertex   = 8'd0;
    sum_res.to_vertex     = 8'd0;
    sum_res.from_slot     = 3'd0;
    sum_res.to_slot       = 3'd0;
    sum_res.vertex_count  = n_d;
    sum_res.edge_count    = mrgd_pkg::edge_cnt(n_d);
    sum_res.status        = sum_st;
    sum_res.last          = 1'b1;
  end

  assign push_o.cnt  = 2'(edge_emit) + 2'(sum_emit);
  assign push_o.res0 = edge_emit ? edge_res : sum_res;
  assign push_o.res1 = sum_res;

  assign in_w8 = code_byte_i - 8'd1;
  assign nx8   = cur_v_d + 8'd1;

  assign mem_req_o.wr_en      = wr_en;
  assign mem_req_o.wr_addr    = wr_addr;
  assign mem_req_o.wr_data    = wr_data;
  assign mem_req_o.rd_en      = acc;
  assign mem_req_o.rd_w_addr  = in_w8[AW-1:0];
  assign mem_req_o.rd_nx_addr = nx8[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      fwd_en_q  <= 1'b0;
      await_q   <= 1'b1;
      bl_q      <= 10'd0;
      cur_v_q   <= 8'd0;
      n_q       <= 8'd0;
      full_q    <= 8'd0;
      err_q     <= mrgd_pkg::ST_OK;
      cur_deg_q <= 3'd0;
      vld_q     <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      await_q   <= await_d;
      bl_q      <= bl_d;
      cur_v_q   <= cur_v_d;
      n_q       <= n_d;
      full_q    <= full_d;
      err_q     <= err_d;
      cur_deg_q <= cur_deg_d;
      if (acc) fwd_en_q <= wr_en;
      if (clr_vld) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stg_byte_q <= code_byte_i;
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

endmodule

// ===== src/mrgd_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one.
// Depends on mrgd_pkg for the result and push structs.
module mrgd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrgd_pkg::push_t  push_i,
  output logic             space_ok_o,
  output logic             valid_o,
  input  logic             stall_i,
  output mrgd_pkg::res_t   res_o
);

  localparam int unsigned PW = mrgd_pkg::OUT_PW;

  mrgd_pkg::res_t  mem_q [mrgd_pkg::OUT_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [PW:0]     cnt_q;
  logic            pop;

  assign valid_o    = (cnt_q != '0);
  assign pop        = valid_o & ~stall_i;
  assign space_ok_o = (cnt_q <= (PW+1)'(mrgd_pkg::OUT_DEPTH - 2));
  assign res_o      = mem_q[rd_ptr_q];
  assign wr_ptr1    = wr_ptr_q + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i.cnt) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr1] <= push_i.res1;
  end

endmodule

// ===== src/multicode_regular_graph_decoder.sv =====
// Top level of the multicode regular graph decoder.
// Depends on mrgd_pkg, mrgd_core, mrgd_deg_mem and mrgd_out_fifo.
//
// Input channel: one code byte per request (valid_i / stall_o). The first
// byte of a graph is its vertex count n; n*DEGREE/2+n-1 code bytes follow.
// Output channel: one result per request (valid_o / stall_i). A nonzero code
// byte inside range gives an edge result with both endpoints and their
// adjacency slots; the last code byte of a graph also gives a summary result
// (kind 1, last 1) with n, the edge count and a status.
// Throughput: one byte per cycle while the input stage is not stalled. A
// byte that yields both an edge and the summary fills two queue entries;
// the output side drains one per cycle while stall_i is low. Path: each
// accepted byte is registered in the input stage, then its results are
// queued. Degree reads go to a two-read-port memory, issued on accept.
// Stall: the result queue holds four entries; the input stage stalls once
// three or more results wait, and nothing is dropped.
// Reset: the block waits for a header byte, all degrees read as zero.
module multicode_regular_graph_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] code_byte_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic       kind_o,
  output logic [7:0] from_vertex_o,
  output logic [7:0] to_vertex_o,
  output logic [2:0] from_slot_o,
  output logic [2:0] to_slot_o,
  output logic [7:0] vertex_count_o,
  output logic [8:0] edge_count_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  mrgd_pkg::mem_req_t mem_req;
  mrgd_pkg::push_t    push;
  mrgd_pkg::res_t     res;
  logic [2:0]         rd_w, rd_nx;
  logic               space_ok;

  mrgd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .code_byte_i (code_byte_i),
    .stall_o     (stall_o),
    .mem_req_o   (mem_req),
    .rd_w_i      (rd_w),
    .rd_nx_i     (rd_nx),
    .space_ok_i  (space_ok),
    .push_o      (push)
  );

  mrgd_deg_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rd_w_o  (rd_w),
    .rd_nx_o (rd_nx)
  );

  mrgd_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .res_o      (res)
  );

  assign kind_o         = res.kind;
  assign from_vertex_o  = res.from_vertex;
  assign to_vertex_o    = res.to_vertex;
  assign from_slot_o    = res.from_slot;
  assign to_slot_o      = res.to_slot;
  assign vertex_count_o = res.vertex_count;
  assign edge_count_o   = res.edge_count;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule

// ===== src/mrgd_checker.sv =====
// Port-level assertions for the multicode regular graph decoder.
// Bound to multicode_regular_graph_decoder; no other dependencies.
module mrgd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       stall_i,
  input logic       kind_o,
  input logic [7:0] from_vertex_o,
  input logic [7:0] to_vertex_o,
  input logic [2:0] from_slot_o,
  input logic [2:0] to_slot_o,
  input logic [7:0] vertex_count_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(kind_o) && $stable(from_vertex_o)
      && $stable(to_vertex_o) && $stable(status_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o |-> last_o && from_vertex_o == 8'd0 && to_vertex_o == 8'd0
      && from_slot_o == 3'd0 && to_slot_o == 3'd0)
    else $error("malformed summary");

  a_edge_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o |-> !last_o && status_o == 2'd0)
    else $error("edge result with last or status set");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o |-> from_vertex_o < vertex_count_o && to_vertex_o < vertex_count_o)
    else $error("edge endpoint outside graph");

  a_loop_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o && from_vertex_o == to_vertex_o |-> from_slot_o == to_slot_o)
    else $error("loop with differing slots");

endmodule

bind multicode_regular_graph_decoder mrgd_checker u_mrgd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .kind_o         (kind_o),
  .from_vertex_o  (from_vertex_o),
  .to_vertex_o    (to_vertex_o),
  .from_slot_o    (from_slot_o),
  .to_slot_o      (to_slot_o),
  .vertex_count_o (vertex_count_o),
  .status_o       (status_o),
  .last_o         (last_o)
);
